/* hw/rtl/lruttl_pkg.sv */
// ---------------------------------------------------------------------------
// LRU cache with TTL expiry - shared definitions
// Codes, states, register indexes and reset values used by the cache block.
// ---------------------------------------------------------------------------
`default_nettype none

package lruttl_pkg;

   localparam int ENTRIES_DEFAULT    = 1024;
   localparam int KEY_BITS_DEFAULT   = 22;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int TICK_W    = 32;
   localparam int CNT_W     = 32;
   localparam int CAP_W     = 11;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int KIND_W    = 3;

   localparam logic [TICK_W-1:0] TTL_RESET = 32'd300;
   localparam logic [CAP_W-1:0]  CAP_RESET = 11'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_TTL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP = 2'd1;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SWEEP  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_EXPIRED  = 3'd2,
      ST_INSERTED = 3'd3,
      ST_UPDATED  = 3'd4,
      ST_EVICTED  = 3'd5,
      ST_DONE     = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_UNL0,
      S_UNL1,
      S_RMW_RD,
      S_RMW_WR,
      S_INVAL,
      S_LINK,
      S_WRS,
      S_EVRD,
      S_EVCAP,
      S_PLACE,
      S_RESP
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      sat_inc = (c == '1) ? c : c + 1'b1;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/lruttl_mem.sv */
// ---------------------------------------------------------------------------
// LRU cache slot memory
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module lruttl_mem
   import lruttl_pkg::*;
#(
   parameter int DEPTH = ENTRIES_DEFAULT,
   parameter int WIDTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/lru_cache_with_ttl_expiry.sv */
// ---------------------------------------------------------------------------
// LRU cache with TTL expiry
// Fully associative key/value cache kept in one slot RAM, with a recency
// chain linked through the slots and a sequencer that searches and relinks.
// ---------------------------------------------------------------------------
//   channel   handshake            payload
//   request   start / busy         req_kind, req_key, req_value
//   response  rsp_strobe (1 cycle) rsp_status .. rsp_expired_count
//   csr       csr_we               csr_index, csr_wdata
//
// Lookup, insert and sweep scan the slot RAM at one slot a cycle while no
// relink or removal is under way; each relink or removal does read-modify-write
// on the single RAM port, and a sweep re-reads one slot after each removal.
// Clear writes every slot empty; after reset that clearing pass runs with busy high.
// The response strobe lasts one cycle and is never held.
`default_nettype none

module lru_cache_with_ttl_expiry
   import lruttl_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEFAULT,
   parameter int KEY_BITS   = KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int AW         = $clog2(ENTRIES),
   parameter int CW         = $clog2(ENTRIES + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_strobe,
   output logic [2:0]                 rsp_status,
   output logic [VALUE_BITS-1:0]      rsp_value_out,
   output logic [CW-1:0]              rsp_entry_count,
   output logic [CNT_W-1:0]           rsp_hit_count,
   output logic [CNT_W-1:0]           rsp_miss_count,
   output logic [CNT_W-1:0]           rsp_expired_count,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [TICK_W-1:0]     created;
      logic [AW-1:0]         newer;
      logic [AW-1:0]         older;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);
   localparam logic [AW:0] SCAN_END = (AW+1)'(ENTRIES);

   state_type             state_ff, state_in;
   state_type             unl_ret_ff, unl_ret_in;
   state_type             inv_ret_ff, inv_ret_in;
   state_type             rmw_ret_ff, rmw_ret_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   status_type            status_ff, status_in;
   logic [VALUE_BITS-1:0] vout_ff, vout_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TICK_W-1:0]     now_ff, now_in;
   logic [CNT_W-1:0]      hits_ff, hits_in;
   logic [CNT_W-1:0]      miss_ff, miss_in;
   logic [CNT_W-1:0]      exp_ff, exp_in;
   logic [AW-1:0]         mr_ff, mr_in;
   logic [AW-1:0]         lr_ff, lr_in;
   logic [TICK_W-1:0]     ttl_ff, ttl_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [AW:0]           scan_ff, scan_in;
   logic [AW-1:0]         chk_ff, chk_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [AW-1:0]         free_ff, free_in;
   logic                  free_vld_ff, free_vld_in;
   logic [AW-1:0]         s_ff, s_in;
   slot_type              sw_ff, sw_in;
   logic [AW-1:0]         rmw_addr_ff, rmw_addr_in;
   logic                  rmw_older_ff, rmw_older_in;
   logic [AW-1:0]         rmw_val_ff, rmw_val_in;
   logic                  link_empty_ff, link_empty_in;
   logic                  clr_resp_ff, clr_resp_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_addr;
   slot_type              mem_wdata;
   logic [SLOT_W-1:0]     mem_rdata;
   slot_type              rd;
   slot_type              rmw_word;
   logic                  rd_expired;
   logic                  key_match;
   logic [CW-1:0]         eff_cap;
   logic                  scan_done;

   lruttl_mem #(
      .DEPTH (ENTRIES),
      .WIDTH (SLOT_W),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rd         = slot_type'(mem_rdata);
   assign rd_expired = (now_ff - rd.created) > ttl_ff;
   assign key_match  = rd.valid && (rd.key == key_ff);
   assign scan_done  = (scan_ff == SCAN_END);

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   always_comb begin
      rmw_word = rd;
      if (rmw_older_ff) begin
         rmw_word.older = rmw_val_ff;
      end else begin
         rmw_word.newer = rmw_val_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      unl_ret_in    = unl_ret_ff;
      inv_ret_in    = inv_ret_ff;
      rmw_ret_in    = rmw_ret_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      vout_in       = vout_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      hits_in       = hits_ff;
      miss_in       = miss_ff;
      exp_in        = exp_ff;
      mr_in         = mr_ff;
      lr_in         = lr_ff;
      ttl_in        = ttl_ff;
      cap_in        = cap_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      free_in       = free_ff;
      free_vld_in   = free_vld_ff;
      s_in          = s_ff;
      sw_in         = sw_ff;
      rmw_addr_in   = rmw_addr_ff;
      rmw_older_in  = rmw_older_ff;
      rmw_val_in    = rmw_val_ff;
      link_empty_in = link_empty_ff;
      clr_resp_in   = clr_resp_ff;
      mem_we        = 1'b0;
      mem_addr      = scan_ff[AW-1:0];
      mem_wdata     = sw_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_TTL: ttl_in = csr_wdata;
            CSR_CAP: cap_in = csr_wdata[CAP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff[AW-1:0] == AW'(ENTRIES - 1)) begin
               mr_in    = '0;
               lr_in    = '0;
               count_in = '0;
               state_in = clr_resp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               kind_in     = req_kind;
               key_in      = req_key;
               val_in      = req_value;
               vout_in     = '0;
               status_in   = ST_DONE;
               scan_in     = '0;
               chk_vld_in  = 1'b0;
               free_vld_in = 1'b0;
               case (req_kind)
                  KIND_LOOKUP, KIND_INSERT, KIND_SWEEP: state_in = S_SCAN;
                  KIND_TICK: begin
                     now_in   = now_ff + 1'b1;
                     state_in = S_RESP;
                  end
                  KIND_CLEAR: begin
                     hits_in     = '0;
                     miss_in     = '0;
                     exp_in      = '0;
                     clr_resp_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            // One read issued per cycle; the word read last cycle is checked.
            chk_vld_in = !scan_done;
            if (!scan_done) begin
               scan_in = scan_ff + 1'b1;
               chk_in  = scan_ff[AW-1:0];
            end
            if (chk_vld_ff) begin
               if (kind_ff == KIND_INSERT && !rd.valid && !free_vld_ff) begin
                  free_in     = chk_ff;
                  free_vld_in = 1'b1;
               end
               case (kind_ff)
                  KIND_LOOKUP: begin
                     if (key_match) begin
                        s_in       = chk_ff;
                        sw_in      = rd;
                        chk_vld_in = 1'b0;
                        if (rd_expired) begin
                           status_in  = ST_EXPIRED;
                           exp_in     = sat_inc(exp_ff);
                           miss_in    = sat_inc(miss_ff);
                           unl_ret_in = S_INVAL;
                           inv_ret_in = S_RESP;
                           state_in   = S_UNL0;
                        end else begin
                           status_in     = ST_HIT;
                           hits_in       = sat_inc(hits_ff);
                           vout_in       = rd.value;
                           link_empty_in = 1'b0;
                           if (chk_ff == mr_ff) begin
                              state_in = S_RESP;
                           end else begin
                              unl_ret_in = S_LINK;
                              state_in   = S_UNL0;
                           end
                        end
                     end
                  end
                  KIND_INSERT: begin
                     if (key_match) begin
                        s_in          = chk_ff;
                        sw_in         = rd;
                        sw_in.value   = val_ff;
                        sw_in.created = now_ff;
                        chk_vld_in    = 1'b0;
                        status_in     = ST_UPDATED;
                        link_empty_in = 1'b0;
                        if (chk_ff == mr_ff) begin
                           state_in = S_WRS;
                        end else begin
                           unl_ret_in = S_LINK;
                           state_in   = S_UNL0;
                        end
                     end
                  end
                  KIND_SWEEP: begin
                     if (rd.valid && rd_expired) begin
                        s_in       = chk_ff;
                        sw_in      = rd;
                        exp_in     = sat_inc(exp_ff);
                        unl_ret_in = S_INVAL;
                        inv_ret_in = S_SCAN;
                        scan_in    = {1'b0, chk_ff} + 1'b1;
                        chk_vld_in = 1'b0;
                        state_in   = S_UNL0;
                     end
                  end
                  default: ;
               endcase
            end else if (scan_done) begin
               case (kind_ff)
                  KIND_LOOKUP: begin
                     miss_in   = sat_inc(miss_ff);
                     status_in = ST_MISS;
                     state_in  = S_RESP;
                  end
                  KIND_INSERT: begin
                     if (count_ff >= eff_cap) begin
                        status_in = ST_EVICTED;
                        state_in  = S_EVRD;
                     end else begin
                        status_in = ST_INSERTED;
                        state_in  = S_PLACE;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_EVRD: begin
            mem_addr = lr_ff;
            state_in = S_EVCAP;
         end
         S_EVCAP: begin
            s_in  = lr_ff;
            sw_in = rd;
            // The new entry takes the lowest free slot once the victim is gone.
            if (!free_vld_ff || lr_ff < free_ff) begin
               free_in     = lr_ff;
               free_vld_in = 1'b1;
            end
            unl_ret_in = S_INVAL;
            inv_ret_in = S_PLACE;
            state_in   = S_UNL0;
         end
         S_UNL0: begin
            if (s_ff == mr_ff) begin
               mr_in    = sw_ff.older;
               state_in = S_UNL1;
            end else begin
               rmw_addr_in  = sw_ff.newer;
               rmw_older_in = 1'b1;
               rmw_val_in   = sw_ff.older;
               rmw_ret_in   = S_UNL1;
               state_in     = S_RMW_RD;
            end
         end
         S_UNL1: begin
            if (s_ff == lr_ff) begin
               lr_in    = sw_ff.newer;
               state_in = unl_ret_ff;
            end else begin
               rmw_addr_in  = sw_ff.older;
               rmw_older_in = 1'b0;
               rmw_val_in   = sw_ff.newer;
               rmw_ret_in   = unl_ret_ff;
               state_in     = S_RMW_RD;
            end
         end
         S_RMW_RD: begin
            mem_addr = rmw_addr_ff;
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            mem_we    = 1'b1;
            mem_addr  = rmw_addr_ff;
            mem_wdata = rmw_word;
            state_in  = rmw_ret_ff;
         end
         S_INVAL: begin
            mem_we          = 1'b1;
            mem_addr        = s_ff;
            mem_wdata       = sw_ff;
            mem_wdata.valid = 1'b0;
            count_in        = count_ff - 1'b1;
            state_in        = inv_ret_ff;
         end
         S_PLACE: begin
            s_in          = free_ff;
            sw_in.valid   = 1'b1;
            sw_in.key     = key_ff;
            sw_in.value   = val_ff;
            sw_in.created = now_ff;
            link_empty_in = (count_ff == '0);
            count_in      = count_ff + 1'b1;
            state_in      = S_LINK;
         end
         S_LINK: begin
            mem_we          = 1'b1;
            mem_addr        = s_ff;
            mem_wdata       = sw_ff;
            mem_wdata.older = mr_ff;
            mem_wdata.newer = s_ff;
            mr_in           = s_ff;
            if (link_empty_ff) begin
               lr_in    = s_ff;
               state_in = S_RESP;
            end else begin
               rmw_addr_in  = mr_ff;
               rmw_older_in = 1'b0;
               rmw_val_in   = s_ff;
               rmw_ret_in   = S_RESP;
               state_in     = S_RMW_RD;
            end
         end
         S_WRS: begin
            mem_we    = 1'b1;
            mem_addr  = s_ff;
            mem_wdata = sw_ff;
            state_in  = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_resp_ff <= 1'b0;
         scan_ff     <= '0;
         chk_vld_ff  <= 1'b0;
         free_vld_ff <= 1'b0;
         count_ff    <= '0;
         now_ff      <= '0;
         hits_ff     <= '0;
         miss_ff     <= '0;
         exp_ff      <= '0;
         mr_ff       <= '0;
         lr_ff       <= '0;
         ttl_ff      <= TTL_RESET;
         cap_ff      <= CAP_RESET;
         unl_ret_ff  <= S_IDLE;
         inv_ret_ff  <= S_IDLE;
         rmw_ret_ff  <= S_IDLE;
      end else begin
         state_ff    <= state_in;
         clr_resp_ff <= clr_resp_in;
         scan_ff     <= scan_in;
         chk_vld_ff  <= chk_vld_in;
         free_vld_ff <= free_vld_in;
         count_ff    <= count_in;
         now_ff      <= now_in;
         hits_ff     <= hits_in;
         miss_ff     <= miss_in;
         exp_ff      <= exp_in;
         mr_ff       <= mr_in;
         lr_ff       <= lr_in;
         ttl_ff      <= ttl_in;
         cap_ff      <= cap_in;
         unl_ret_ff  <= unl_ret_in;
         inv_ret_ff  <= inv_ret_in;
         rmw_ret_ff  <= rmw_ret_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      vout_ff       <= vout_in;
      chk_ff        <= chk_in;
      free_ff       <= free_in;
      s_ff          <= s_in;
      sw_ff         <= sw_in;
      rmw_addr_ff   <= rmw_addr_in;
      rmw_older_ff  <= rmw_older_in;
      rmw_val_ff    <= rmw_val_in;
      link_empty_ff <= link_empty_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = (state_ff == S_RESP);
   assign rsp_status        = status_ff;
   assign rsp_value_out     = vout_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_hit_count     = hits_ff;
   assign rsp_miss_count    = miss_ff;
   assign rsp_expired_count = exp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count above slot count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe while idle");

endmodule

`default_nettype wire
